[hdl/eic_pkg.sv]
// Shared types and constants for the edge interval capture block.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package eic_pkg;

   // Record store geometry
   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int REC_W       = 8;
   localparam int COUNT_W     = 8;
   localparam int EDGE_W      = 16;
   // Limit compare width: one bit above the count so the full depth fits
   localparam int LIM_W       = COUNT_W + 1;

   // Register reset values and indexes
   localparam logic [7:0] SYNC_RESET  = 8'd130;
   localparam logic [7:0] LIMIT_RESET = 8'd132;
   localparam logic       CSR_SYNC    = 1'b0;
   localparam logic       CSR_LIMIT   = 1'b1;

   // Record layout: falling-edge flag above the elapsed bits
   localparam logic [REC_W-1:0] FALL_MARK = 8'h80;

   // Stream widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      OP_EDGE    = 2'd0,
      OP_TIMEOUT = 2'd1,
      OP_READ    = 2'd2,
      OP_ARM     = 2'd3
   } op_type;

   // Access to the record store issued with an accepted request
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [REC_W-1:0]  wdata;
      logic              re;
      logic [ADDR_W-1:0] raddr;
   } store_cmd_type;

   // Result fields known at accept time; read data joins in the cycle after
   typedef struct packed {
      logic               record_stored;
      logic [REC_W-1:0]   record_value;
      logic [7:0]         record_index;
      logic               restart_timer;
      logic               capture_active;
      logic               capture_done;
      logic [COUNT_W-1:0] record_count;
      logic               read_hit;
      logic [EDGE_W-1:0]  edge_count;
   } rsp_fields_type;

endpackage
`default_nettype wire

[hdl/eic_store.sv]
// Record store: one write port and one read port with registered read data.
// Depends on eic_pkg for geometry and the access command type.
`default_nettype none
module eic_store
   import eic_pkg::*;
(
   input  wire logic             clock,
   input  wire store_cmd_type    cmd,
   output logic [REC_W-1:0]      rd_data
);

   logic [REC_W-1:0] mem [STORE_DEPTH];

   // Write records as edges store them
   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.waddr] <= cmd.wdata;
      end
   end

   // Read data is registered and appears in the cycle after the request; hold otherwise
   always_ff @(posedge clock) begin
      if (cmd.re) begin
         rd_data <= mem[cmd.raddr];
      end
   end

endmodule
`default_nettype wire

[hdl/eic_ctrl.sv]
// Capture control: flags, counters and registers; issues record store accesses.
// Depends on eic_pkg. Entry validity follows from the fill count, since a
// capture writes positions in order from zero.
`default_nettype none
module eic_ctrl
   import eic_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire op_type        operation,
   input  wire logic [7:0]    elapsed,
   input  wire logic          pin_level,
   input  wire logic [7:0]    read_index,
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [7:0]    csr_wdata,
   output store_cmd_type      cmd,
   output rsp_fields_type     fields
);

   logic [7:0]         sync_ff, sync_in;
   logic [7:0]         limit_ff, limit_in;
   logic               active_ff, active_in;
   logic               armed_ff, armed_in;
   logic               done_ff, done_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [EDGE_W-1:0]  edge_ff, edge_in;

   logic               start;
   logic               in_capture;
   logic [COUNT_W-1:0] base_count;
   logic [LIM_W-1:0]   limit_eff;
   logic               has_room;
   logic [REC_W-1:0]   rec;

   // Clamp the record limit to the store depth
   always_comb begin
      if ({{(LIM_W-8){1'b0}}, limit_ff} > LIM_W'(STORE_DEPTH)) begin
         limit_eff = LIM_W'(STORE_DEPTH);
      end else begin
         limit_eff = {{(LIM_W-8){1'b0}}, limit_ff};
      end
   end

   assign start      = !active_ff && (elapsed == sync_ff);
   assign in_capture = active_ff || start;
   assign base_count = start ? '0 : count_ff;
   assign has_room   = {{(LIM_W-COUNT_W){1'b0}}, base_count} < limit_eff;
   assign rec        = {~pin_level, elapsed[6:0]} & (FALL_MARK | 8'h7F);

   // Next state and result fields for the accepted request
   always_comb begin
      active_in = active_ff;
      armed_in  = armed_ff;
      done_in   = done_ff;
      count_in  = count_ff;
      edge_in   = edge_ff;
      cmd       = '0;
      fields    = '0;
      cmd.raddr = read_index[ADDR_W-1:0];
      cmd.waddr = base_count[ADDR_W-1:0];
      cmd.wdata = rec;
      if (accept) begin
         case (operation)
            OP_EDGE: begin
               if (armed_ff) begin
                  edge_in              = edge_ff + 1'b1;
                  fields.restart_timer = 1'b1;
                  if (in_capture) begin
                     active_in = 1'b1;
                     count_in  = base_count;
                     if (has_room) begin
                        cmd.we               = 1'b1;
                        fields.record_stored = 1'b1;
                        fields.record_value  = rec;
                        fields.record_index  = 8'(base_count);
                        count_in             = base_count + 1'b1;
                     end else begin
                        active_in = 1'b0;
                        armed_in  = 1'b0;
                        done_in   = 1'b1;
                     end
                  end
               end
            end
            OP_TIMEOUT: begin
               if (active_ff) begin
                  active_in            = 1'b0;
                  armed_in             = 1'b0;
                  done_in              = 1'b1;
                  fields.restart_timer = 1'b1;
               end
            end
            OP_READ: begin
               cmd.re          = 1'b1;
               fields.read_hit = ({1'b0, read_index} < LIM_W'(STORE_DEPTH)) &&
                                 (read_index < count_ff);
            end
            OP_ARM: begin
               armed_in = 1'b1;
               done_in  = 1'b0;
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end
      fields.capture_active = active_in;
      fields.capture_done   = done_in;
      fields.record_count   = count_in;
      fields.edge_count     = edge_in;
   end

   // Take register writes
   always_comb begin
      sync_in  = sync_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SYNC:  sync_in  = csr_wdata;
            CSR_LIMIT: limit_in = csr_wdata;
            default:   sync_in  = sync_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff   <= SYNC_RESET;
         limit_ff  <= LIMIT_RESET;
         active_ff <= 1'b0;
         armed_ff  <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
         edge_ff   <= '0;
      end else begin
         sync_ff   <= sync_in;
         limit_ff  <= limit_in;
         active_ff <= active_in;
         armed_ff  <= armed_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
         edge_ff   <= edge_in;
      end
   end

   // A capture in progress is always armed
   a_active_armed: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> armed_ff)
      else $error("capture active while disarmed");

   // Done and armed exclude each other
   a_done_disarmed: assert property (@(posedge clock) disable iff (reset)
      !(done_ff && armed_ff))
      else $error("done and armed together");

   // Edge counter moves only on an armed edge
   a_edge_hold: assert property (@(posedge clock) disable iff (reset)
      !(accept && operation == OP_EDGE && armed_ff) |=> $stable(edge_ff))
      else $error("edge counter moved without an armed edge");

   // A store write only happens inside a capture
   a_write_active: assert property (@(posedge clock) disable iff (reset)
      cmd.we |=> active_ff || done_ff)
      else $error("record written outside a capture");

endmodule
`default_nettype wire

[hdl/edge_interval_capture.sv]
// Top level of the edge interval capture block: stream ports, output register.
// Depends on eic_pkg, eic_ctrl and eic_store.
//
//   port group | direction | payload (low bit first)
//   req_*      | in        | tuser: operation; tdata: elapsed, pin_level, read_index
//   rsp_*      | out       | tdata: record_stored, record_value, record_index,
//              |           |   restart_timer, capture_active, capture_done,
//              |           |   record_count, read_data, edge_count
//   csr_*      | in        | write index 0 sync_interval, 1 record_limit
//
// One request per cycle while results are taken; each result appears in the
// cycle after its request. The state update finishes in the accept cycle and
// the store read data is registered by the memory port, so back-to-back
// accesses to one entry see the previous write. Synchronous reset clears flags
// and counters and loads the registers with their reset values; the store
// needs no clearing, validity comes from the fill count. A stalled result
// holds and the block takes a new request in the same cycle the result leaves.
`default_nettype none
module edge_interval_capture
   import eic_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_tuser,   // operation
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // elapsed, pin_level, read_index
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // record_stored, record_value,
                                                   // record_index, restart_timer,
                                                   // capture_active, capture_done,
                                                   // record_count, read_data,
                                                   // edge_count
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [7:0]            csr_wdata
);

   logic            accept;
   op_type          operation;
   store_cmd_type   cmd;
   rsp_fields_type  fields;
   rsp_fields_type  out_ff;
   logic            valid_ff, valid_in;
   logic [REC_W-1:0] rd_data;
   logic [7:0]      read_data;

   assign req_tready = !valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign operation  = op_type'(req_tuser);

   eic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (operation),
      .elapsed    (req_tdata[7:0]),
      .pin_level  (req_tdata[8]),
      .read_index (req_tdata[16:9]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .fields     (fields)
   );

   eic_store u_store (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   // Hold the result until taken
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_ff <= fields;
      end
   end

   // Drop unwritten entries to zero
   assign read_data  = out_ff.read_hit ? rd_data : 8'd0;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0,
                        out_ff.edge_count,
                        read_data,
                        out_ff.record_count,
                        out_ff.capture_done,
                        out_ff.capture_active,
                        out_ff.restart_timer,
                        out_ff.record_index,
                        out_ff.record_value,
                        out_ff.record_stored};

endmodule
`default_nettype wire
